@@ hdl/ifcm_pkg.sv @@
// shared types, constants and register map of the infrared false-color mapper
`timescale 1ns / 1ps
package ifcm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WSZ_W  = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W  = $clog2(MAX_HEIGHT + 1);

  localparam int MODE_W = 3;
  localparam int SIZE_W = 11;
  localparam int PIX_W  = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd240;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_GREY     = 3'd0,
    MODE_NIGHT    = 3'd1,
    MODE_THERMAL  = 3'd2,
    MODE_SCANLINE = 3'd3,
    MODE_PINK     = 3'd4,
    MODE_SEPIA    = 3'd5,
    MODE_NEON     = 3'd6,
    MODE_GREY_ALT = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] ir_value;
    mode_t            mode;
    logic             phase_zero;
    logic             eof;
  } pix_entry_t;

endpackage

@@ hdl/ifcm_front.sv @@
// front end: raster position tracking and classification of each pixel
`timescale 1ns / 1ps
module ifcm_front
  import ifcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mode_t             mode,
  input  logic [SIZE_W-1:0] image_width,
  input  logic [SIZE_W-1:0] image_height,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  ir_value,
  output logic              push_valid,
  input  logic              push_ready,
  output pix_entry_t        push_entry
);

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [1:0]       row_phase;

  logic [WSZ_W-1:0] width_eff;
  logic [HSZ_W-1:0] height_eff;
  logic [WSZ_W-1:0] column_plus;
  logic [HSZ_W-1:0] row_plus;
  logic             last_col;
  logic             last_row;
  logic             accept;

  always_comb begin
    if (image_width == '0) begin
      width_eff = WSZ_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      width_eff = WSZ_W'(MAX_WIDTH);
    end else begin
      width_eff = WSZ_W'(image_width);
    end
    if (image_height == '0) begin
      height_eff = HSZ_W'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      height_eff = HSZ_W'(MAX_HEIGHT);
    end else begin
      height_eff = HSZ_W'(image_height);
    end
  end

  assign column_plus = WSZ_W'(column_count) + WSZ_W'(1);
  assign row_plus    = HSZ_W'(row_count) + HSZ_W'(1);
  assign last_col    = column_plus >= width_eff;
  assign last_row    = row_plus >= height_eff;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  always_comb begin
    push_entry.ir_value   = ir_value;
    push_entry.mode       = mode;
    push_entry.phase_zero = (row_phase == 2'd0);
    push_entry.eof        = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_phase    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        if (last_row) begin
          row_count <= '0;
          row_phase <= '0;
        end else begin
          row_count <= ROW_W'(row_plus);
          row_phase <= (row_phase >= 2'd2) ? 2'd0 : row_phase + 2'd1;
        end
      end else begin
        column_count <= COL_W'(column_plus);
      end
    end
  end

  a_eof_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && push_entry.eof |=> column_count == '0 && row_count == '0 && row_phase == '0)
    else $error("counters did not wrap after last pixel of frame");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    row_phase != 2'd3)
    else $error("row phase out of range");

endmodule

@@ hdl/ifcm_queue.sv @@
// short queue between the front end and the color pipeline
`timescale 1ns / 1ps
module ifcm_queue
  import ifcm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  pix_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output pix_entry_t pop_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    count == '0 || count == CNT_W'(QUEUE_DEPTH) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");

endmodule

@@ hdl/ifcm_back.sv @@
// color pipeline: numerators, divide by ten with saturation, scanline third and packing
`timescale 1ns / 1ps
module ifcm_back
  import ifcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  pix_entry_t        pop_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] abgr_pixel,
  output logic              end_of_frame
);

  localparam int NUM_W  = 12;
  localparam int PROD_W = 28;
  localparam int SHIFT  = 19;
  localparam logic [PROD_W-1:0] RECIP10 = 28'd52429;
  localparam int THIRD_W = 17;
  localparam logic [THIRD_W-1:0] RECIP3 = 17'd171;

  // stage a: numerators
  logic             a_valid;
  logic [NUM_W-1:0] a_num [3];
  logic [2:0]       a_div;
  logic             a_third;
  logic             a_eof;

  // stage b: channels after divide and saturation
  logic             b_valid;
  logic [PIX_W-1:0] b_chan [3];
  logic             b_third;
  logic             b_eof;

  logic rdy_a;
  logic rdy_b;
  logic rdy_c;

  logic [NUM_W-1:0] n_num [3];
  logic [2:0]       n_div;
  logic [PIX_W-1:0] v;
  logic [5:0]       lo;
  logic [PIX_W-1:0] lo4;
  logic [NUM_W-1:0] vw;
  logic [NUM_W-1:0] xw;

  logic [PROD_W-1:0] prod [3];
  logic [8:0]        quot [3];
  logic [PIX_W-1:0]  sat [3];

  logic [THIRD_W-1:0] third_prod;
  logic [PIX_W-1:0]   green_out;

  assign rdy_c     = !out_valid || out_ready;
  assign rdy_b     = !b_valid || rdy_c;
  assign rdy_a     = !a_valid || rdy_b;
  assign pop_ready = rdy_a;

  assign v   = pop_entry.ir_value;
  assign lo  = v[5:0];
  assign lo4 = {lo, 2'b00};
  assign vw  = NUM_W'(v);
  assign xw  = NUM_W'(v[6:0]);

  // index 0 red, 1 green, 2 blue
  always_comb begin
    n_num[0] = '0;
    n_num[1] = '0;
    n_num[2] = '0;
    n_div    = 3'b000;
    unique case (pop_entry.mode)
      MODE_NIGHT: begin
        n_num[0] = NUM_W'(v[7:2]);
        n_num[1] = vw + NUM_W'(50);
        n_num[2] = NUM_W'(v[7:3]);
      end
      MODE_THERMAL: begin
        unique case (v[7:6])
          2'd0: begin
            n_num[2] = NUM_W'(lo4);
          end
          2'd1: begin
            n_num[1] = NUM_W'(lo4);
            n_num[2] = NUM_W'(255);
          end
          2'd2: begin
            n_num[0] = NUM_W'(lo4);
            n_num[1] = NUM_W'(255);
            n_num[2] = NUM_W'(8'd255 - lo4);
          end
          default: begin
            n_num[0] = NUM_W'(255);
            n_num[1] = NUM_W'(8'd255 - lo4);
          end
        endcase
      end
      MODE_SCANLINE: begin
        n_num[1] = vw * NUM_W'(16);
        n_div    = 3'b010;
      end
      MODE_PINK: begin
        n_num[0] = vw * NUM_W'(13);
        n_num[1] = vw * NUM_W'(4);
        n_num[2] = vw * NUM_W'(11);
        n_div    = 3'b111;
      end
      MODE_SEPIA: begin
        n_num[0] = vw * NUM_W'(11);
        n_num[1] = vw * NUM_W'(9);
        n_num[2] = vw * NUM_W'(6);
        n_div    = 3'b111;
      end
      MODE_NEON: begin
        if (!v[7]) begin
          n_num[0] = vw * NUM_W'(5);
          n_num[2] = vw * NUM_W'(15);
          n_div    = 3'b101;
        end else begin
          n_num[0] = NUM_W'(255);
          n_num[1] = xw * NUM_W'(15);
          n_num[2] = NUM_W'(2550) - xw * NUM_W'(15);
          n_div    = 3'b110;
        end
      end
      default: begin
        n_num[0] = vw;
        n_num[1] = vw;
        n_num[2] = vw;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i] = PROD_W'(a_num[i]) * RECIP10;
      quot[i] = a_div[i] ? prod[i][SHIFT+8:SHIFT] : a_num[i][8:0];
      sat[i]  = (quot[i] > 9'd255) ? 8'd255 : quot[i][7:0];
    end
  end

  assign third_prod = THIRD_W'(b_chan[1]) * RECIP3;
  assign green_out  = b_third ? third_prod[16:9] : b_chan[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_valid <= pop_valid;
      end
      if (rdy_b) begin
        b_valid <= a_valid;
      end
      if (rdy_c) begin
        out_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && pop_valid) begin
      a_num   <= n_num;
      a_div   <= n_div;
      a_third <= (pop_entry.mode == MODE_SCANLINE) && pop_entry.phase_zero;
      a_eof   <= pop_entry.eof;
    end
    if (rdy_b && a_valid) begin
      b_chan  <= sat;
      b_third <= a_third;
      b_eof   <= a_eof;
    end
    if (rdy_c && b_valid) begin
      abgr_pixel   <= {8'hFF, b_chan[2], green_out, b_chan[0]};
      end_of_frame <= b_eof;
    end
  end

  a_alpha: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> abgr_pixel[31:24] == 8'hFF)
    else $error("alpha byte not opaque");

  a_b_hold: assert property (@(posedge clk) disable iff (rst)
    b_valid && !rdy_c |=> b_valid && $stable(b_eof))
    else $error("stage b lost its item under stall");

endmodule

@@ hdl/ir_false_color_mapper.sv @@
// top level of the infrared false-color mapper with its register port
//
// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------
// input    | in_valid / in_ready  | ir_value
// output   | out_valid / out_ready| abgr_pixel, end_of_frame
// config   | psel/penable/pwrite  | paddr, pwdata, prdata (pready high)
//
// one pixel transfer per cycle in steady state on both channels while out_ready stays high
// an input transfer passes a two-entry queue and three pipeline stages on its way to the result
// the front passes the queue's ready straight back; the back stalls on its own; the queue absorbs a stall of the output
// rst clears counters, queue and pipeline valid bits and loads register defaults
`timescale 1ns / 1ps
module ir_false_color_mapper
  import ifcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  ir_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] abgr_pixel,
  output logic              end_of_frame,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  mode_t             filter_mode;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;
  reg_idx_t          reg_idx;
  logic              wr_en;

  logic       push_valid;
  logic       push_ready;
  pix_entry_t push_entry;
  logic       pop_valid;
  logic       pop_ready;
  pix_entry_t pop_entry;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_GREY;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:   filter_mode  <= mode_t'(pwdata[MODE_W-1:0]);
        REG_WIDTH:  image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = DATA_W'(filter_mode);
      REG_WIDTH:  prdata = DATA_W'(image_width);
      REG_HEIGHT: prdata = DATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  ifcm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .mode         (filter_mode),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ir_value     (ir_value),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  ifcm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  ifcm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .abgr_pixel   (abgr_pixel),
    .end_of_frame (end_of_frame)
  );

endmodule

@@ test/tb_ir_false_color_mapper.sv @@
// self-checking stream testbench of the infrared false-color mapper with its own color predictor
`timescale 1ns / 1ps
module tb_ir_false_color_mapper;
  import ifcm_pkg::*;

  typedef struct {
    logic [DATA_W-1:0] pixel;
    logic              eof;
  } color_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  ir_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] abgr_pixel;
  logic              end_of_frame;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // predictor copy of the registers and the raster position
  mode_t             mode_cfg = MODE_GREY;
  logic [SIZE_W-1:0] width_cfg = WIDTH_RESET;
  logic [SIZE_W-1:0] height_cfg = HEIGHT_RESET;
  int unsigned       col_pos = 0;
  int unsigned       row_pos = 0;
  int unsigned       row_mod3 = 0;

  logic [PIX_W-1:0]  pending_pixels[$];
  color_result_t     expected_colors[$];
  int unsigned       pixels_queued = 0;
  int unsigned       pixels_checked = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       send_gap_pct = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       hold_request = 0;
  int unsigned       hold_seen = 0;
  int unsigned       hold_left = 0;

  ir_false_color_mapper i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .ir_value     (ir_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .abgr_pixel   (abgr_pixel),
    .end_of_frame (end_of_frame),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk = ~clk;

  function automatic int unsigned scale_sat(input int unsigned v, input int unsigned tenths);
    int unsigned p;
    p = v * tenths / 10;
    return (p > 255) ? 255 : p;
  endfunction

  function automatic logic [DATA_W-1:0] shade_pixel(input int unsigned v, input mode_t m,
                                                     input logic phase0);
    int unsigned r, g, b, x;
    r = 0;
    g = 0;
    b = 0;
    case (m)
      MODE_NIGHT: begin
        r = v >> 2;
        g = (v + 50 > 255) ? 255 : v + 50;
        b = v >> 3;
      end
      MODE_THERMAL: begin
        if (v < 64) begin
          b = v * 4;
        end else if (v < 128) begin
          g = (v - 64) * 4;
          b = 255;
        end else if (v < 192) begin
          r = (v - 128) * 4;
          g = 255;
          b = 255 - (v - 128) * 4;
        end else begin
          r = 255;
          g = 255 - (v - 192) * 4;
        end
      end
      MODE_SCANLINE: begin
        g = scale_sat(v, 16);
        if (phase0) g = g / 3;
      end
      MODE_PINK: begin
        r = scale_sat(v, 13);
        g = scale_sat(v, 4);
        b = scale_sat(v, 11);
      end
      MODE_SEPIA: begin
        r = scale_sat(v, 11);
        g = scale_sat(v, 9);
        b = scale_sat(v, 6);
      end
      MODE_NEON: begin
        if (v < 128) begin
          r = v * 5 / 10;
          b = v * 15 / 10;
        end else begin
          x = v - 128;
          r = 255;
          g = x * 15 / 10;
          b = (2550 - x * 15) / 10;
        end
      end
      default: begin
        r = v;
        g = v;
        b = v;
      end
    endcase
    return {8'hFF, b[7:0], g[7:0], r[7:0]};
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] v);
    int unsigned w, h;
    logic last_col, last_row;
    color_result_t res;
    w = (width_cfg == 0) ? 1 : (width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg;
    h = (height_cfg == 0) ? 1 : (height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : height_cfg;
    last_col = (col_pos + 1 >= w);
    last_row = (row_pos + 1 >= h);
    res.pixel = shade_pixel(32'(v), mode_cfg, row_mod3 == 0);
    res.eof = last_col && last_row;
    expected_colors.push_back(res);
    if (last_col) begin
      col_pos = 0;
      if (last_row) begin
        row_pos = 0;
        row_mod3 = 0;
      end else begin
        row_pos++;
        row_mod3 = (row_mod3 == 2) ? 0 : row_mod3 + 1;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic flag_error(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // driver: one transfer offered from the pending queue, held until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_pixel(ir_value);
      if (!in_valid || in_ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          ir_value <= pending_pixels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer and drives out_ready
  always @(posedge clk) begin : monitor
    color_result_t want;
    if (!rst && out_valid && out_ready) begin
      pixels_checked++;
      if (expected_colors.size() == 0) begin
        flag_error($sformatf("unexpected result %h eof %b", abgr_pixel, end_of_frame));
      end else begin
        want = expected_colors.pop_front();
        if (abgr_pixel !== want.pixel || end_of_frame !== want.eof)
          flag_error($sformatf("expected %h eof %b, got %h eof %b",
                               want.pixel, want.eof, abgr_pixel, end_of_frame));
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = 150;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] word;
    // junk above the field must be dropped by the block
    word = (idx == REG_MODE) ? ($urandom() << MODE_W) | value : ($urandom() << SIZE_W) | value;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MODE:   mode_cfg = mode_t'(word[MODE_W-1:0]);
      REG_WIDTH:  width_cfg = word[SIZE_W-1:0];
      REG_HEIGHT: height_cfg = word[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input mode_t m, input int unsigned w, input int unsigned h);
    write_reg(REG_MODE, DATA_W'(m));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic queue_pixel(input logic [PIX_W-1:0] v);
    pending_pixels.push_back(v);
    pixels_queued++;
  endtask

  task automatic drain;
    while (pixels_checked < pixels_queued) @(posedge clk);
  endtask

  task automatic run_pixels(input int unsigned n);
    repeat (n) queue_pixel(PIX_W'($urandom_range(0, 255)));
    drain();
  endtask

  function automatic int unsigned pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 0;
      1: return 1;
      7: return $urandom_range(9, 40);
      8: return 1024;
      9: return $urandom_range(1025, 2047);
      default: return $urandom_range(2, 8);
    endcase
  endfunction

  task automatic random_phases(input int unsigned budget);
    int unsigned done, n;
    done = 0;
    while (done < budget) begin
      n = $urandom_range(8, 40);
      write_reg(REG_MODE, $urandom_range(0, 7));
      if ($urandom_range(0, 2) != 0) write_reg(REG_WIDTH, pick_size());
      if ($urandom_range(0, 2) != 0) write_reg(REG_HEIGHT, pick_size());
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, $urandom());
      run_pixels(n);
      done += n;
    end
  endtask

  initial begin : stimulus
    mode_t m;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: every mode with the value extremes and segment edges
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    m = MODE_GREY;
    do begin
      write_reg(REG_MODE, DATA_W'(m));
      queue_pixel(8'd0);
      queue_pixel(8'd255);
      case (m)
        MODE_THERMAL: begin
          queue_pixel(8'd63);
          queue_pixel(8'd64);
          queue_pixel(8'd127);
          queue_pixel(8'd128);
          queue_pixel(8'd191);
          queue_pixel(8'd192);
        end
        MODE_NEON: begin
          queue_pixel(8'd127);
          queue_pixel(8'd128);
        end
        MODE_SCANLINE: begin
          queue_pixel(8'd255);
          queue_pixel(8'd255);
        end
        default: ;
      endcase
      drain();
      m = m.next();
    end while (m != MODE_GREY);

    send_gap_pct = 28;
    recv_stall_pct = 51;
    random_phases(170);

    send_gap_pct = 51;
    recv_stall_pct = 28;
    // oversize width clamps at the maximum, zero height acts as one row
    set_frame(mode_t'($urandom_range(0, 7)), 2047, 0);
    run_pixels(1030);
    random_phases(150);

    send_gap_pct = 0;
    recv_stall_pct = 0;
    set_frame(MODE_SCANLINE, 4, 3);
    hold_request++;
    run_pixels(60);
    set_frame(MODE_THERMAL, 1, 1);
    run_pixels(10);
    set_frame(MODE_NEON, 1024, 1024);
    run_pixels(10);
    random_phases(150);

    drain();
    repeat (12) @(posedge clk);
    if (expected_colors.size() != 0) flag_error("results missing at end of run");
    if (mismatch_count == 0) begin
      $display("ir_false_color_mapper test passed");
    end else begin
      $display("ir_false_color_mapper test failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("ir_false_color_mapper test failed");
    $finish;
  end

endmodule
